@@ hdl/waveform_shaper_ten_shape_defines.svh @@
// Assertion macros for the ten-shape waveform shaper checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef WAVEFORM_SHAPER_TEN_SHAPE_DEFINES_SVH
`define WAVEFORM_SHAPER_TEN_SHAPE_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define WSTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define WSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wsts_pkg.sv @@
// Shared constants, types and the quarter-wave sine table builder for the
// ten-shape waveform shaper. No dependencies.
package wsts_pkg;

    localparam int PHASE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_IN_W      = 16;
    localparam int SAMPLE_W        = 16;
    localparam int MAG_W           = 15;
    localparam int MAG2_W          = 29;
    localparam int CUBE_W          = 43;
    localparam int SAW_W           = 15;
    localparam int QUAD_BITS       = PHASE_BITS - 2;
    localparam int SINE_STEPS      = 1 << SINE_TABLE_BITS;
    localparam int SINE_ENTRIES    = SINE_STEPS + 1;
    localparam int Q14_ONE         = 16384;
    localparam int Q14_FRAC        = 14;
    localparam int CUBE_FRAC       = 28;

    typedef logic [PHASE_BITS-1:0]        t_phase;
    typedef logic [PHASE_IN_W-1:0]        t_phase_in;
    typedef logic [3:0]                   t_shape;
    typedef logic [MAG_W-1:0]             t_mag;
    typedef logic signed [SAMPLE_W-1:0]   t_sample;
    typedef logic [SINE_TABLE_BITS:0]     t_sine_idx;
    typedef logic [SINE_ENTRIES-1:0][MAG_W-1:0] t_sine_tab;

    localparam t_shape SHAPE_SINE         = 4'd0;
    localparam t_shape SHAPE_HALF_SINE    = 4'd1;
    localparam t_shape SHAPE_ABS_SINE     = 4'd2;
    localparam t_shape SHAPE_QUARTER      = 4'd3;
    localparam t_shape SHAPE_DOUBLE       = 4'd4;
    localparam t_shape SHAPE_ABS_DOUBLE   = 4'd5;
    localparam t_shape SHAPE_SQUARE       = 4'd6;
    localparam t_shape SHAPE_HALF_COS     = 4'd7;
    localparam t_shape SHAPE_ROUND_SQUARE = 4'd8;
    localparam t_shape SHAPE_CUBED_SAW    = 4'd9;

    localparam t_phase  QUARTER_TURN = t_phase'(1 << (PHASE_BITS - 2));
    localparam t_mag    Q14_MAG      = t_mag'(Q14_ONE);
    localparam t_sample Q14_SAMPLE   = t_sample'(Q14_ONE);

    // Stage 2 beat: table magnitude plus everything later stages need
    typedef struct packed {
        t_mag               sin_mag;
        logic               sin_neg;
        logic               first_half;
        logic               first_quarter;
        t_shape             shape;
        logic               saw_neg;
        t_mag               saw_mag;
        logic [MAG2_W-1:0]  saw_sq;
    } t_lookup;

    // Stage 4 beat
    typedef struct packed {
        t_mag               sin_mag;
        logic               sin_neg;
        logic               first_half;
        logic               first_quarter;
        t_shape             shape;
        logic [MAG2_W-1:0]  fold_sq;
        logic               saw_neg;
        t_mag               saw_cube;
    } t_poly;

    typedef struct packed {
        logic s3;
        logic s4;
    } t_poly_en;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                               64'd42, 64'd20, 64'd6};

    // Quarter-wave sine in Q14, Taylor series evaluated in Q30 at elaboration
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        tab = '0;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            x  = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int i = 0; i < 6; i++) begin
                t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
            end
            v = (((x * t) >> 30) + 64'd32768) >> 16;
            if (v > 64'(Q14_ONE)) begin
                v = 64'(Q14_ONE);
            end
            tab[k] = v[MAG_W-1:0];
        end
        return tab;
    endfunction

endpackage

@@ hdl/waveform_shaper_ten_shape.sv @@
// Ten-shape waveform shaper: five register stages, one beat per cycle while the output
// is not stalled; a result passes through each stage register in turn, and each full
// stage holds while the one after it cannot load.
// Stages: capture, ROM read, two multiplier stages, output select register.
// Reset (synchronous, active low) empties the pipeline and sets the shape to sine.
module waveform_shaper_ten_shape (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wsts_pkg::t_shape     i_cfg_wave_shape,
    input  logic                 i_phase_valid,
    output logic                 o_phase_ready,
    input  wsts_pkg::t_phase_in  i_phase_turn,
    output logic                 o_sample_valid,
    input  logic                 i_sample_ready,
    output wsts_pkg::t_sample    o_sample
);
    import wsts_pkg::*;

    t_shape     r_wave_shape;
    logic       r_s1_valid;
    logic       r_s2_valid;
    logic       r_s3_valid;
    logic       r_s4_valid;
    logic       r_out_valid;
    t_phase     r_s1_phase;
    t_shape     r_s1_shape;
    t_shape     n_s1_shape;
    t_sample    r_sample;
    t_sample    n_sample;

    logic       en1;
    logic       en2;
    logic       en5;
    t_poly_en   poly_en;
    t_lookup    lookup;
    t_poly      poly;

    logic [MAG2_W-1:0] fold_rnd;
    t_mag       fold_a4;
    t_sample    sine_s;
    t_sample    mag_s;
    t_sample    round_s;
    t_sample    saw_s;

    // a stage loads when it is empty or its contents move on
    assign en5        = !r_out_valid || i_sample_ready;
    assign poly_en.s4 = !r_s4_valid || en5;
    assign poly_en.s3 = !r_s3_valid || poly_en.s4;
    assign en2        = !r_s2_valid || poly_en.s3;
    assign en1        = !r_s1_valid || en2;

    assign o_cfg_ready   = 1'b1;
    assign o_phase_ready = en1;
    assign o_sample_valid = r_out_valid;
    assign o_sample       = r_sample;

    assign n_s1_shape = (r_wave_shape > SHAPE_CUBED_SAW) ? SHAPE_CUBED_SAW : r_wave_shape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape <= SHAPE_SINE;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_s4_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wave_shape <= i_cfg_wave_shape;
            end
            if (en1) begin
                r_s1_valid <= i_phase_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (poly_en.s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (poly_en.s4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (en5) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_phase <= PHASE_BITS'(i_phase_turn);
            r_s1_shape <= n_s1_shape;
        end
        if (en5) begin
            r_sample <= n_sample;
        end
    end

    wsts_lookup u_lookup (
        .i_clk    (i_clk),
        .i_en     (en2),
        .i_phase  (r_s1_phase),
        .i_shape  (r_s1_shape),
        .o_lookup (lookup)
    );

    wsts_poly u_poly (
        .i_clk    (i_clk),
        .i_en     (poly_en),
        .i_lookup (lookup),
        .o_poly   (poly)
    );

    always_comb begin
        fold_rnd = poly.fold_sq + MAG2_W'(Q14_ONE / 2);
        fold_a4  = fold_rnd[Q14_FRAC +: MAG_W];
        mag_s    = t_sample'(poly.sin_mag);
        sine_s   = poly.sin_neg ? -mag_s : mag_s;
        round_s  = t_sample'(Q14_MAG - fold_a4);
        saw_s    = poly.saw_neg ? -t_sample'(poly.saw_cube) : t_sample'(poly.saw_cube);

        unique case (poly.shape)
            SHAPE_SINE, SHAPE_HALF_COS: begin
                n_sample = sine_s;
            end
            SHAPE_HALF_SINE, SHAPE_DOUBLE: begin
                n_sample = poly.first_half ? sine_s : '0;
            end
            SHAPE_ABS_SINE: begin
                n_sample = mag_s;
            end
            SHAPE_QUARTER: begin
                n_sample = poly.first_quarter ? sine_s : '0;
            end
            SHAPE_ABS_DOUBLE: begin
                n_sample = poly.first_half ? mag_s : '0;
            end
            SHAPE_SQUARE: begin
                n_sample = poly.first_half ? Q14_SAMPLE : -Q14_SAMPLE;
            end
            SHAPE_ROUND_SQUARE: begin
                n_sample = poly.first_half ? round_s : -round_s;
            end
            default: begin
                n_sample = saw_s;
            end
        endcase
    end

endmodule

@@ hdl/wsts_lookup.sv @@
// Stage 2 of the shaper: sine phase select, quarter-wave ROM read and saw square.
// Depends on wsts_pkg.
module wsts_lookup (
    input  logic             i_clk,
    input  logic             i_en,
    input  wsts_pkg::t_phase i_phase,
    input  wsts_pkg::t_shape i_shape,
    output wsts_pkg::t_lookup o_lookup
);
    import wsts_pkg::*;

    localparam t_sine_tab SINE_ROM = build_sine_tab();

    t_phase                                   lk_phase;
    logic [1:0]                               quad;
    logic [QUAD_BITS+SINE_TABLE_BITS-1:0]     frac_wide;
    logic [SINE_TABLE_BITS-1:0]               step;
    t_sine_idx                                idx;
    logic [PHASE_BITS+SAW_W-1:0]              saw_wide;
    t_mag                                     saw_trunc;
    logic                                     saw_neg;
    t_mag                                     saw_mag;
    t_lookup                                  r_lookup;

    always_comb begin
        unique case (i_shape)
            SHAPE_DOUBLE, SHAPE_ABS_DOUBLE: begin
                lk_phase = {i_phase[PHASE_BITS-2:0], 1'b0};
            end
            SHAPE_HALF_COS: begin
                lk_phase = (i_phase >> 1) + QUARTER_TURN;
            end
            default: begin
                lk_phase = i_phase;
            end
        endcase

        quad = lk_phase[PHASE_BITS-1 -: 2];
        // top table bits of the in-quadrant phase, zero-filled if the phase is narrower
        frac_wide = {lk_phase[QUAD_BITS-1:0], {SINE_TABLE_BITS{1'b0}}};
        step      = frac_wide[QUAD_BITS+SINE_TABLE_BITS-1 -: SINE_TABLE_BITS];
        idx       = quad[0] ? (t_sine_idx'(SINE_STEPS) - {1'b0, step}) : {1'b0, step};

        // 2n truncated to Q14
        saw_wide  = {i_phase, {SAW_W{1'b0}}};
        saw_trunc = saw_wide[PHASE_BITS +: SAW_W];
        saw_neg   = saw_trunc > Q14_MAG;
        saw_mag   = saw_neg ? (saw_trunc - Q14_MAG) : (Q14_MAG - saw_trunc);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lookup.sin_mag       <= SINE_ROM[idx];
            r_lookup.sin_neg       <= quad[1];
            r_lookup.first_half    <= !i_phase[PHASE_BITS-1];
            r_lookup.first_quarter <= (i_phase[PHASE_BITS-1 -: 2] == 2'b00);
            r_lookup.shape         <= i_shape;
            r_lookup.saw_neg       <= saw_neg;
            r_lookup.saw_mag       <= saw_mag;
            r_lookup.saw_sq        <= MAG2_W'(saw_mag) * MAG2_W'(saw_mag);
        end
    end

    assign o_lookup = r_lookup;

endmodule

@@ hdl/wsts_poly.sv @@
// Stages 3 and 4: the rounded-square fourth power (one multiply per stage, Q14
// rounding between) and the saw cube, rounded Q42 to Q14. Depends on wsts_pkg.
module wsts_poly (
    input  logic               i_clk,
    input  wsts_pkg::t_poly_en i_en,
    input  wsts_pkg::t_lookup  i_lookup,
    output wsts_pkg::t_poly    o_poly
);
    import wsts_pkg::*;

    typedef struct packed {
        t_mag               sin_mag;
        logic               sin_neg;
        logic               first_half;
        logic               first_quarter;
        t_shape             shape;
        logic [MAG2_W-1:0]  fold_a_sq;
        logic               saw_neg;
        logic [CUBE_W-1:0]  saw_cube;
    } t_fold;

    t_mag               fold_a;
    logic [MAG2_W-1:0]  fold_a_sq_rnd;
    t_mag               fold_a2;
    logic [CUBE_W-1:0]  cube_rnd;
    t_fold              r_fold;
    t_poly              r_poly;

    always_comb begin
        fold_a        = Q14_MAG - i_lookup.sin_mag;
        fold_a_sq_rnd = r_fold.fold_a_sq + MAG2_W'(Q14_ONE / 2);
        fold_a2       = fold_a_sq_rnd[Q14_FRAC +: MAG_W];
        cube_rnd      = r_fold.saw_cube + (CUBE_W'(1) << (CUBE_FRAC - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_fold.sin_mag       <= i_lookup.sin_mag;
            r_fold.sin_neg       <= i_lookup.sin_neg;
            r_fold.first_half    <= i_lookup.first_half;
            r_fold.first_quarter <= i_lookup.first_quarter;
            r_fold.shape         <= i_lookup.shape;
            r_fold.fold_a_sq     <= MAG2_W'(fold_a) * MAG2_W'(fold_a);
            r_fold.saw_neg       <= i_lookup.saw_neg;
            r_fold.saw_cube      <= CUBE_W'(i_lookup.saw_sq) * CUBE_W'(i_lookup.saw_mag);
        end
        if (i_en.s4) begin
            r_poly.sin_mag       <= r_fold.sin_mag;
            r_poly.sin_neg       <= r_fold.sin_neg;
            r_poly.first_half    <= r_fold.first_half;
            r_poly.first_quarter <= r_fold.first_quarter;
            r_poly.shape         <= r_fold.shape;
            r_poly.fold_sq       <= MAG2_W'(fold_a2) * MAG2_W'(fold_a2);
            r_poly.saw_neg       <= r_fold.saw_neg;
            r_poly.saw_cube      <= cube_rnd[CUBE_FRAC +: MAG_W];
        end
    end

    assign o_poly = r_poly;

endmodule

@@ hdl/wsts_checker.sv @@
// Port-level checker for the ten-shape waveform shaper, bound to the top level.
// Depends on wsts_pkg and waveform_shaper_ten_shape_defines.svh.
`include "waveform_shaper_ten_shape_defines.svh"

module wsts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_phase_ready,
    input logic                o_sample_valid,
    input logic                i_sample_ready,
    input wsts_pkg::t_sample   o_sample
);
    import wsts_pkg::*;

    `WSTS_ASSERT_NEXT(a_out_valid_holds, o_sample_valid && !i_sample_ready, o_sample_valid, "sample beat dropped while stalled")
    `WSTS_ASSERT_NEXT(a_out_data_holds, o_sample_valid && !i_sample_ready, $stable(o_sample), "sample changed while stalled")
    `WSTS_ASSERT_NOW(a_sample_range, o_sample_valid, (o_sample <= Q14_SAMPLE) && (o_sample >= -Q14_SAMPLE), "sample outside plus or minus one")
    `WSTS_ASSERT_NOW(a_ready_when_drained, i_sample_ready, o_phase_ready, "input blocked with output open")

endmodule

bind waveform_shaper_ten_shape wsts_checker u_wsts_checker (.*);

@@ tb/testbench.sv @@
// Self-checking bench for waveform_shaper_ten_shape: phase beats in, Q2.14 samples out.
// Expected samples come from an in-bench model of all ten shapes over a quarter-wave table.
// Depends on wsts_pkg for port types and shape codes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsts_pkg::*;

    localparam int     ITEMS_PER_SEG  = 78;
    localparam int     SEG_COUNT      = 16;
    localparam int     CALM_SEG       = 5;
    localparam int     IDLE_PCT       = 18;
    localparam int     HOLD_AFTER     = 600;
    localparam int     HOLD_CYCLES    = 60;
    localparam int     TAIL_CYCLES    = 12;
    localparam int     MAX_PRINTED    = 20;
    localparam int     DIR_COUNT      = 24;
    localparam t_shape SHAPE_OVER_MAX = 4'd15;

    // Taylor divisors, innermost term first
    localparam bit [63:0] TERM_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    localparam bit [63:0] RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam bit [63:0] ONE_Q30         = 64'd1073741824;

    localparam t_shape DIR_SHAPE [DIR_COUNT] = '{
        SHAPE_SINE, SHAPE_SINE, SHAPE_SINE, SHAPE_SINE,
        SHAPE_HALF_SINE, SHAPE_HALF_SINE, SHAPE_ABS_SINE, SHAPE_ABS_SINE,
        SHAPE_QUARTER, SHAPE_QUARTER, SHAPE_DOUBLE, SHAPE_DOUBLE,
        SHAPE_ABS_DOUBLE, SHAPE_ABS_DOUBLE, SHAPE_SQUARE, SHAPE_SQUARE,
        SHAPE_HALF_COS, SHAPE_HALF_COS, SHAPE_ROUND_SQUARE, SHAPE_ROUND_SQUARE,
        SHAPE_CUBED_SAW, SHAPE_CUBED_SAW, SHAPE_OVER_MAX, SHAPE_OVER_MAX
    };
    localparam t_phase_in DIR_PHASE [DIR_COUNT] = '{
        16'h0000, 16'h4000, 16'hC000, 16'hFFFF,
        16'h7FFF, 16'h8000, 16'hC000, 16'h3FFF,
        16'h3FFF, 16'h4000, 16'h2000, 16'h7FFF,
        16'h6000, 16'h8001, 16'h7FFF, 16'h8000,
        16'h0001, 16'hFFFF, 16'h4000, 16'hC000,
        16'h0000, 16'h8000, 16'hFFFF, 16'h0001
    };

    class shaped_sample_board;
        t_sample     awaited_samples[$];
        t_shape      shape_reg;
        int unsigned quarter_q14 [SINE_ENTRIES];
        int          errors;

        function new();
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] t;
            bit [63:0] v;
            for (int k = 0; k < SINE_ENTRIES; k++) begin
                x  = (RIGHT_ANGLE_Q30 * 64'(k)) / 64'(SINE_STEPS);
                x2 = (x * x) >> 30;
                t  = ONE_Q30;
                for (int i = 0; i < 6; i++) begin
                    t = ONE_Q30 - ((x2 * t) >> 30) / TERM_DIV[i];
                end
                v = (((x * t) >> 30) + 64'd32768) >> 16;
                if (v > 64'(Q14_ONE)) begin
                    v = 64'(Q14_ONE);
                end
                quarter_q14[k] = int'(v);
            end
            shape_reg = SHAPE_SINE;
            errors    = 0;
        endfunction

        function int sine_at(t_phase ph);
            int idx;
            int v;
            idx = int'(ph[QUAD_BITS-1:0]) >> (QUAD_BITS - SINE_TABLE_BITS);
            if (ph[QUAD_BITS]) begin
                idx = SINE_STEPS - idx;
            end
            v = int'(quarter_q14[idx]);
            return ph[QUAD_BITS+1] ? -v : v;
        endfunction

        function t_sample shape_sample(t_phase_in p);
            t_phase ph;
            bit     first_half;
            int     s;
            int     a;
            int     a2;
            int     a4;
            int     r;
            longint saw;
            longint m;
            longint c;
            ph         = t_phase'(p);
            first_half = !ph[PHASE_BITS-1];
            s          = sine_at(ph);
            case (shape_reg)
                SHAPE_SINE:       r = s;
                SHAPE_HALF_SINE:  r = first_half ? s : 0;
                SHAPE_ABS_SINE:   r = s < 0 ? -s : s;
                SHAPE_QUARTER:    r = ph < QUARTER_TURN ? s : 0;
                SHAPE_DOUBLE:     r = first_half ? sine_at(t_phase'(ph << 1)) : 0;
                SHAPE_ABS_DOUBLE: begin
                    r = first_half ? sine_at(t_phase'(ph << 1)) : 0;
                    r = r < 0 ? -r : r;
                end
                SHAPE_SQUARE:     r = first_half ? Q14_ONE : -Q14_ONE;
                SHAPE_HALF_COS:   r = sine_at(t_phase'((ph >> 1) + QUARTER_TURN));
                SHAPE_ROUND_SQUARE: begin
                    a  = Q14_ONE - (s < 0 ? -s : s);
                    a2 = (a * a + 8192) >> 14;
                    a4 = (a2 * a2 + 8192) >> 14;
                    r  = first_half ? Q14_ONE - a4 : a4 - Q14_ONE;
                end
                default: begin
                    // cubed saw; codes above nine land here too
                    saw = longint'(Q14_ONE) - ((longint'(ph) << 15) >>> PHASE_BITS);
                    m   = saw < 0 ? -saw : saw;
                    c   = (m * m * m + (64'sd1 << 27)) >>> 28;
                    r   = int'(saw < 0 ? -c : c);
                end
            endcase
            return t_sample'(r);
        endfunction

        function void set_shape(t_shape v);
            shape_reg = v;
        endfunction

        function void note_phase(t_phase_in p);
            awaited_samples.push_back(shape_sample(p));
        endfunction

        function int pending();
            return awaited_samples.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endtask

        task check_sample(t_sample got);
            t_sample want;
            if (awaited_samples.size() == 0) begin
                report($sformatf("sample %0d with none awaited", got));
            end else begin
                want = awaited_samples.pop_front();
                if (got !== want) begin
                    report($sformatf("sample got %0d want %0d", got, want));
                end
            end
        endtask
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      cfg_valid    = 1'b0;
    t_shape    cfg_shape    = '0;
    logic      phase_valid  = 1'b0;
    t_phase_in phase_turn   = '0;
    logic      sample_ready = 1'b0;
    logic      cfg_ready;
    logic      phase_ready;
    logic      sample_valid;
    t_sample   sample;

    bit calm         = 1'b0;
    int samples_seen = 0;

    shaped_sample_board board = new();

    waveform_shaper_ten_shape i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_wave_shape (cfg_shape),
        .i_phase_valid    (phase_valid),
        .o_phase_ready    (phase_ready),
        .i_phase_turn     (phase_turn),
        .o_sample_valid   (sample_valid),
        .i_sample_ready   (sample_ready),
        .o_sample         (sample)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && sample_valid && sample_ready) begin
            board.check_sample(sample);
            samples_seen++;
        end
    end

    // Output side: random stalls, plus one long hold-off so the pipe backs up
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && samples_seen >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                sample_ready <= 1'b0;
            end else begin
                sample_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_phase_in pick_phase();
        t_phase_in p;
        case ($urandom_range(3))
            0, 1: p = t_phase_in'($urandom);
            // around a quadrant boundary
            2: p = t_phase_in'({$urandom_range(3), 14'b0} + $urandom_range(8) - 4);
            // just off the table grid
            default: p = t_phase_in'({$urandom_range(4095), 4'b0} + $urandom_range(2) - 1);
        endcase
        return p;
    endfunction

    task automatic send_phase(input t_phase_in p);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            phase_valid <= 1'b0;
            @(negedge clk);
        end
        phase_valid <= 1'b1;
        phase_turn  <= p;
        do @(posedge clk); while (!phase_ready);
        board.note_phase(p);
        @(negedge clk);
    endtask

    task automatic drain();
        phase_valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
    endtask

    task automatic write_shape(input t_shape v);
        cfg_valid <= 1'b1;
        cfg_shape <= v;
        do @(posedge clk); while (!cfg_ready);
        board.set_shape(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first group runs on the reset shape
        for (int i = 0; i < DIR_COUNT; i++) begin
            if (DIR_SHAPE[i] != board.shape_reg) begin
                drain();
                write_shape(DIR_SHAPE[i]);
            end
            send_phase(DIR_PHASE[i]);
        end

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            drain();
            write_shape(t_shape'(seg));
            calm = (seg == CALM_SEG);
            repeat (ITEMS_PER_SEG) send_phase(pick_phase());
            calm = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (board.pending() != 0) begin
            board.report($sformatf("%0d samples never arrived", board.pending()));
        end
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
